FILE: design/assert_macros.svh
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds in the same cycle
`define BFTM_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("bftm check failed");

// property whose consequent holds in the cycle after the antecedent
`define BFTM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bftm check failed");

`endif

FILE: design/bftm_pkg.sv
// types and constants of the tape machine step block
`default_nettype none

package bftm_pkg;

	localparam int unsigned ADDR_W = 17;
	localparam int unsigned CELL_W = 8;
	localparam int unsigned RET_W  = 16;
	localparam int unsigned CNT_W  = 8;

	localparam logic [ADDR_W-1:0] PROG_SIZE = 17'd65536;
	localparam logic [CNT_W-1:0]  SKIP_MAX  = 8'd255;

	localparam logic [7:0] CMD_PTR_INC  = 8'h3E; // >
	localparam logic [7:0] CMD_PTR_DEC  = 8'h3C; // <
	localparam logic [7:0] CMD_CELL_INC = 8'h2B; // +
	localparam logic [7:0] CMD_CELL_DEC = 8'h2D; // -
	localparam logic [7:0] CMD_OPEN     = 8'h5B; // [
	localparam logic [7:0] CMD_CLOSE    = 8'h5D; // ]
	localparam logic [7:0] CMD_READ     = 8'h2C; // ,
	localparam logic [7:0] CMD_WRITE    = 8'h2E; // .

	typedef enum logic [1:0] {
		FAULT_NONE      = 2'd0,
		FAULT_OVERFLOW  = 2'd1,
		FAULT_UNMATCHED = 2'd2
	} fault_t;

	typedef struct packed {
		logic [ADDR_W-1:0] next_address;
		logic              out_valid;
		logic [CELL_W-1:0] out_byte;
		logic              halted;
		fault_t            fault_code;
	} result_t;

endpackage

`default_nettype wire

FILE: design/bftm_if.sv
// valid/ready channel interfaces for instruction and result words
`default_nettype none

interface bftm_in_if import bftm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [7:0]        instruction;
	logic [CELL_W-1:0] in_byte;

	modport source (output valid, output instruction, output in_byte, input ready);
	modport sink (input valid, input instruction, input in_byte, output ready);
endinterface

interface bftm_out_if import bftm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] next_address;
	logic              out_valid;
	logic [CELL_W-1:0] out_byte;
	logic              halted;
	fault_t            fault_code;

	modport source (output valid, output next_address, output out_valid, output out_byte,
		output halted, output fault_code, input ready);
	modport sink (input valid, input next_address, input out_valid, input out_byte,
		input halted, input fault_code, output ready);
endinterface

`default_nettype wire

FILE: design/bftm_ram.sv
// simple dual-port ram with registered read
`default_nettype none

module bftm_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: design/bf_tape_machine_step.sv
// tape machine step: one instruction word in, one result word out
//
//   channel   dir  handshake        payload
//   fetch     in   valid/ready      instruction, in_byte
//   result    out  valid/ready      next_address, out_valid, out_byte, halted, fault_code
//   cfg       in   cfg_we           cfg_wdata (program length)
//
// a word is read from the tape and stack rams in the accept cycle, and its cell is modified
// and written back when it leaves the execute stage, before a new word is taken.
// after reset the tape is cleared, one cell a cycle, until all TAPE_CELLS cells are zero;
// fetch.ready stays low meanwhile.
// a result stalled on the output keeps the execute stage, and a new word is taken only
// once that stage has drained.
`default_nettype none

module bf_tape_machine_step import bftm_pkg::*; #(
	parameter int unsigned TAPE_CELLS = 32768,
	parameter int unsigned LOOP_DEPTH = 255
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [ADDR_W-1:0] cfg_wdata,
	bftm_in_if.sink           fetch,
	bftm_out_if.source        result
);

	localparam int unsigned TA = $clog2(TAPE_CELLS);
	localparam int unsigned SA = $clog2(LOOP_DEPTH);
	localparam logic [TA-1:0]    DP_LAST   = TA'(TAPE_CELLS - 1);
	localparam logic [CNT_W-1:0] DEPTH_MAX = CNT_W'(LOOP_DEPTH);

	logic              clr_busy_q;
	logic [TA-1:0]     clr_idx_q;
	logic [ADDR_W-1:0] plen_q;
	logic [TA-1:0]     dp_q;
	logic [ADDR_W-1:0] pc_q;
	logic [CNT_W-1:0]  sd_q;
	logic [CNT_W-1:0]  skip_q;
	logic              stopped_q;

	logic              valid_s1;
	logic [7:0]        instr_s1;
	logic [CELL_W-1:0] inb_s1;

	logic              out_full_q;
	result_t           result_q;

	logic              accept;
	logic              fire_s1;
	logic [CELL_W-1:0] cell_rd;
	logic [RET_W-1:0]  ret;
	logic [CNT_W-1:0]  sd_dec;

	logic [TA-1:0]     n_dp;
	logic [ADDR_W-1:0] n_pc;
	logic [ADDR_W-1:0] next;
	logic [CNT_W-1:0]  n_sd;
	logic [CNT_W-1:0]  n_skip;
	logic              n_stop;
	logic              tape_we;
	logic [CELL_W-1:0] cell_new;
	logic              stk_we;
	logic              ov;
	logic [CELL_W-1:0] ob;
	fault_t            fault;
	result_t           res;

	logic              tram_we;
	logic [TA-1:0]     tram_waddr;
	logic [CELL_W-1:0] tram_wdata;

	assign accept  = fetch.valid && fetch.ready;
	assign fire_s1 = valid_s1 && (!out_full_q || result.ready);
	assign sd_dec  = sd_q - 8'd1;

	assign fetch.ready = !clr_busy_q && !valid_s1;

	assign tram_we    = clr_busy_q || (fire_s1 && tape_we);
	assign tram_waddr = clr_busy_q ? clr_idx_q : dp_q;
	assign tram_wdata = clr_busy_q ? '0 : cell_new;

	bftm_ram #(.WIDTH(CELL_W), .DEPTH(TAPE_CELLS)) u_tape (
		.clk   (clk),
		.we    (tram_we),
		.waddr (tram_waddr),
		.wdata (tram_wdata),
		.re    (accept),
		.raddr (dp_q),
		.rdata (cell_rd)
	);

	bftm_ram #(.WIDTH(RET_W), .DEPTH(LOOP_DEPTH)) u_stack (
		.clk   (clk),
		.we    (fire_s1 && stk_we),
		.waddr (sd_q[SA-1:0]),
		.wdata (pc_q[RET_W-1:0]),
		.re    (accept),
		.raddr (sd_dec[SA-1:0]),
		.rdata (ret)
	);

	always_comb begin
		n_dp     = dp_q;
		n_pc     = pc_q;
		n_sd     = sd_q;
		n_skip   = skip_q;
		n_stop   = stopped_q;
		tape_we  = 1'b0;
		cell_new = cell_rd;
		stk_we   = 1'b0;
		ov       = 1'b0;
		ob       = '0;
		fault    = FAULT_NONE;
		next     = pc_q + 17'd1;
		res      = '{next_address: pc_q, out_valid: 1'b0, out_byte: '0,
			halted: 1'b1, fault_code: FAULT_NONE};
		if (stopped_q || pc_q >= plen_q) begin
			n_stop = 1'b1;
		end else begin
			if (skip_q != '0) begin
				if (instr_s1 == CMD_OPEN) begin
					if (skip_q >= SKIP_MAX) begin
						fault = FAULT_OVERFLOW;
					end else begin
						n_skip = skip_q + 8'd1;
					end
				end else if (instr_s1 == CMD_CLOSE) begin
					n_skip = skip_q - 8'd1;
				end
			end else begin
				case (instr_s1)
					CMD_PTR_INC: begin
						n_dp = (dp_q == DP_LAST) ? '0 : dp_q + 1'b1;
					end
					CMD_PTR_DEC: begin
						n_dp = (dp_q == '0) ? DP_LAST : dp_q - 1'b1;
					end
					CMD_CELL_INC: begin
						tape_we  = 1'b1;
						cell_new = cell_rd + 8'd1;
					end
					CMD_CELL_DEC: begin
						tape_we  = 1'b1;
						cell_new = cell_rd - 8'd1;
					end
					CMD_OPEN: begin
						if (cell_rd == '0) begin
							n_skip = 8'd1;
						end else if (sd_q >= DEPTH_MAX) begin
							fault = FAULT_OVERFLOW;
						end else begin
							stk_we = 1'b1;
							n_sd   = sd_q + 8'd1;
						end
					end
					CMD_CLOSE: begin
						if (sd_q == '0) begin
							fault = FAULT_UNMATCHED;
						end else if (cell_rd != '0) begin
							next = {1'b0, ret} + 17'd1;
						end else begin
							n_sd = sd_dec;
						end
					end
					CMD_READ: begin
						tape_we  = 1'b1;
						cell_new = inb_s1;
					end
					CMD_WRITE: begin
						ov = 1'b1;
						ob = cell_rd;
					end
					default: begin
					end
				endcase
			end
			if (fault != FAULT_NONE) begin
				n_stop = 1'b1;
				res.fault_code = fault;
			end else begin
				n_pc   = next;
				n_stop = (next >= plen_q);
				res    = '{next_address: next, out_valid: ov, out_byte: ob,
					halted: n_stop, fault_code: FAULT_NONE};
			end
		end
	end

	// tape clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == DP_LAST) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q <= '0;
		end else if (cfg_we) begin
			plen_q <= (cfg_wdata > PROG_SIZE) ? PROG_SIZE : cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dp_q      <= '0;
			pc_q      <= '0;
			sd_q      <= '0;
			skip_q    <= '0;
			stopped_q <= 1'b0;
		end else if (fire_s1) begin
			dp_q      <= n_dp;
			pc_q      <= n_pc;
			sd_q      <= n_sd;
			skip_q    <= n_skip;
			stopped_q <= n_stop;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			out_full_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (fire_s1) begin
				valid_s1 <= 1'b0;
			end
			if (fire_s1) begin
				out_full_q <= 1'b1;
			end else if (result.ready) begin
				out_full_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			instr_s1 <= fetch.instruction;
			inb_s1   <= fetch.in_byte;
		end
		if (fire_s1) begin
			result_q <= res;
		end
	end

	assign result.valid        = out_full_q;
	assign result.next_address = result_q.next_address;
	assign result.out_valid    = result_q.out_valid;
	assign result.out_byte     = result_q.out_byte;
	assign result.halted       = result_q.halted;
	assign result.fault_code   = result_q.fault_code;

endmodule

`default_nettype wire

FILE: design/bftm_checker.sv
// port-level checks for the tape machine step block and their binding
`default_nettype none
`include "assert_macros.svh"

module bftm_checker import bftm_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              fetch_valid,
	input logic              fetch_ready,
	input logic              result_valid,
	input logic              result_ready,
	input logic [ADDR_W-1:0] next_address,
	input logic              out_valid,
	input logic [CELL_W-1:0] out_byte,
	input logic              halted,
	input logic [1:0]        fault_code
);

	// a fault always comes with a halt
	`BFTM_ASSERT(a_fault_halts, clk, arst_n, !result_valid || fault_code == FAULT_NONE || halted)

	// only the three fault codes appear
	`BFTM_ASSERT(a_fault_known, clk, arst_n, !result_valid || fault_code <= FAULT_UNMATCHED)

	// no output byte without a write command
	`BFTM_ASSERT(a_byte_zero, clk, arst_n, !result_valid || out_valid || out_byte == '0)

	// a word taken blocks the next cycle
	`BFTM_ASSERT_NEXT(a_gap, clk, arst_n, fetch_valid && fetch_ready, !fetch_ready)

	// stalled result holds
	`BFTM_ASSERT_NEXT(a_hold, clk, arst_n, result_valid && !result_ready, $stable({result_valid, next_address}))

endmodule

bind bf_tape_machine_step bftm_checker u_bftm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.fetch_valid  (fetch.valid),
	.fetch_ready  (fetch.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.next_address (result.next_address),
	.out_valid    (result.out_valid),
	.out_byte     (result.out_byte),
	.halted       (result.halted),
	.fault_code   (result.fault_code)
);

`default_nettype wire

FILE: tb/tape_machine_checker.sv
// checker that predicts every result word of the tape machine step block and compares it
module tape_machine_checker import bftm_pkg::*; #(
	parameter int unsigned TAPE_CELLS = 32768,
	parameter int unsigned LOOP_DEPTH = 255
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [ADDR_W-1:0] cfg_wdata,
	bftm_in_if                fetch,
	bftm_out_if               result,
	output int unsigned       fail_count,
	output int unsigned       pending_count
);

	localparam int unsigned PTR_W = $clog2(TAPE_CELLS);

	logic [CELL_W-1:0] tape [TAPE_CELLS];
	logic [PTR_W-1:0]  data_ptr;
	logic [ADDR_W-1:0] pc;
	logic [ADDR_W-1:0] loop_returns [LOOP_DEPTH];
	int unsigned       loop_count;
	logic [CNT_W-1:0]  skip_count;
	logic              halt_latched;
	logic [ADDR_W-1:0] prog_length;
	result_t           predicted_words [$];

	task automatic report_mismatch(input string what, input int unsigned got,
		input int unsigned predicted);
		$display("mismatch at %0t: %s got 0x%0h, predicted 0x%0h", $time, what, got,
			predicted);
		fail_count++;
	endtask

	// the machine stops and reports the address it stopped at
	function automatic result_t halt_word(input fault_t code);
		result_t word;
		word = '0;
		halt_latched = 1'b1;
		word.next_address = pc;
		word.halted = 1'b1;
		word.fault_code = code;
		return word;
	endfunction

	function automatic result_t run_instruction(input logic [7:0] op,
		input logic [CELL_W-1:0] data);
		result_t           word;
		logic [ADDR_W-1:0] target;
		word = '0;
		target = pc + 1'b1;
		if (halt_latched || pc >= prog_length)
			return halt_word(FAULT_NONE);
		if (skip_count != '0) begin
			// skipping a loop body: only brackets count
			if (op == CMD_OPEN) begin
				if (skip_count == SKIP_MAX)
					return halt_word(FAULT_OVERFLOW);
				skip_count++;
			end else if (op == CMD_CLOSE) begin
				skip_count--;
			end
		end else begin
			case (op)
			CMD_PTR_INC: begin
				data_ptr = (data_ptr == PTR_W'(TAPE_CELLS - 1)) ? '0 : data_ptr + 1'b1;
			end
			CMD_PTR_DEC: begin
				data_ptr = (data_ptr == '0) ? PTR_W'(TAPE_CELLS - 1) : data_ptr - 1'b1;
			end
			CMD_CELL_INC: begin
				tape[data_ptr] = tape[data_ptr] + 1'b1;
			end
			CMD_CELL_DEC: begin
				tape[data_ptr] = tape[data_ptr] - 1'b1;
			end
			CMD_OPEN: begin
				if (tape[data_ptr] == '0) begin
					skip_count = CNT_W'(1);
				end else if (loop_count >= LOOP_DEPTH) begin
					return halt_word(FAULT_OVERFLOW);
				end else begin
					loop_returns[loop_count] = pc;
					loop_count++;
				end
			end
			CMD_CLOSE: begin
				if (loop_count == 0)
					return halt_word(FAULT_UNMATCHED);
				if (tape[data_ptr] != '0)
					target = loop_returns[loop_count - 1] + 1'b1;
				else
					loop_count--;
			end
			CMD_READ: begin
				tape[data_ptr] = data;
			end
			CMD_WRITE: begin
				word.out_valid = 1'b1;
				word.out_byte = tape[data_ptr];
			end
			default: begin
			end
			endcase
		end
		pc = target;
		if (pc >= prog_length)
			halt_latched = 1'b1;
		word.next_address = pc;
		word.halted = halt_latched;
		return word;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			foreach (tape[i])
				tape[i] = '0;
			data_ptr = '0;
			pc = '0;
			loop_count = 0;
			skip_count = '0;
			halt_latched = 1'b0;
			prog_length = '0;
			predicted_words.delete();
			fail_count = 0;
			pending_count = 0;
		end else begin
			if (cfg_we)
				prog_length = (cfg_wdata > PROG_SIZE) ? PROG_SIZE : cfg_wdata;
			if (fetch.valid && fetch.ready)
				predicted_words.push_back(run_instruction(fetch.instruction, fetch.in_byte));
			if (result.valid && result.ready) begin
				if (predicted_words.size() == 0) begin
					report_mismatch("result word with nothing pending", 0, 0);
				end else begin
					want = predicted_words.pop_front();
					if (result.next_address !== want.next_address)
						report_mismatch("next_address", result.next_address, want.next_address);
					if (result.out_valid !== want.out_valid)
						report_mismatch("out_valid", result.out_valid, want.out_valid);
					if (result.out_byte !== want.out_byte)
						report_mismatch("out_byte", result.out_byte, want.out_byte);
					if (result.halted !== want.halted)
						report_mismatch("halted", result.halted, want.halted);
					if (result.fault_code !== want.fault_code)
						report_mismatch("fault_code", result.fault_code, want.fault_code);
				end
			end
			pending_count = predicted_words.size();
		end
	end

endmodule

FILE: tb/tb.sv
// testbench top: drives instruction words and program lengths, paces results, gives the verdict
module tb;
	import bftm_pkg::*;

	localparam int unsigned RANDOM_WORDS  = 1900;
	localparam int unsigned MAX_GAP       = 17;
	localparam int unsigned LONG_HOLD     = 300;
	localparam int unsigned IDLE_LIMIT    = 150000;
	localparam int unsigned SETTLE_CYCLES = 20;
	localparam int unsigned FULL_RUN      = 256;

	typedef enum int {
		END_REACH,
		END_BEYOND,
		END_UNMATCHED,
		END_STACK_FULL,
		END_SKIP_FULL,
		END_SKIP_RUNOFF
	} ending_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [ADDR_W-1:0] cfg_wdata;
	int unsigned       fail_count;
	int unsigned       pending_count;
	int unsigned       idle_cycles;
	int unsigned       loop_depth;
	int unsigned       skip_level;
	int unsigned       words_sent;
	logic [ADDR_W-1:0] last_address;
	bit                hold_request;
	bit                burst_in;
	bit                burst_out;

	bftm_in_if  fetch_if ();
	bftm_out_if result_if ();

	bf_tape_machine_step DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.fetch     (fetch_if),
		.result    (result_if)
	);

	tape_machine_checker step_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.fetch         (fetch_if),
		.result        (result_if),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// caller must send again or drain in the same step, or the word is taken twice
	task automatic send_word(input logic [7:0] op, input logic [7:0] data);
		int unsigned gap;
		if ($urandom_range(0, 47) == 0)
			burst_in = !burst_in;
		gap = burst_in ? 0 : $urandom_range(0, MAX_GAP);
		if (gap != 0) begin
			fetch_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		fetch_if.valid <= 1'b1;
		fetch_if.instruction <= op;
		fetch_if.in_byte <= data;
		do @(posedge clk); while (!fetch_if.ready);
		words_sent++;
	endtask

	task automatic drain();
		fetch_if.valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
	endtask

	task automatic write_length(input logic [ADDR_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255)); while (b == CMD_OPEN || b == CMD_CLOSE);
		return b;
	endfunction

	function automatic logic [7:0] plain_command();
		case ($urandom_range(0, 5))
		0: return CMD_PTR_INC;
		1: return CMD_PTR_DEC;
		2: return CMD_CELL_INC;
		3: return CMD_CELL_DEC;
		4: return CMD_READ;
		default: return CMD_WRITE;
		endcase
	endfunction

	// the cell is set just before the bracket so the loop depth stays known
	task automatic close_loop(input bit again);
		send_word(CMD_READ, again ? 8'($urandom_range(1, 255)) : 8'h00);
		send_word(CMD_CLOSE, rand_byte());
		if (!again)
			loop_depth--;
	endtask

	task automatic random_chunk();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (skip_level != 0) begin
			if (pick < 25 && skip_level < 200) begin
				send_word(CMD_OPEN, rand_byte());
				skip_level++;
			end else if (pick < 55) begin
				send_word(CMD_CLOSE, rand_byte());
				skip_level--;
			end else begin
				send_word(plain_byte(), rand_byte());
			end
		end else if (pick < 45) begin
			send_word(plain_command(), rand_byte());
		end else if (pick < 55) begin
			send_word(plain_byte(), rand_byte());
		end else if (pick < 67 && loop_depth < 200) begin
			send_word(CMD_READ, 8'($urandom_range(1, 255)));
			send_word(CMD_OPEN, rand_byte());
			loop_depth++;
		end else if (pick < 72) begin
			send_word(CMD_READ, 8'h00);
			send_word(CMD_OPEN, rand_byte());
			skip_level = 1;
		end else if (pick < 84 && loop_depth != 0) begin
			close_loop(1'b1);
		end else if (loop_depth != 0) begin
			close_loop(1'b0);
		end else begin
			send_word(plain_command(), rand_byte());
		end
	endtask

	// result side
	initial begin
		int unsigned gap;
		result_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if ($urandom_range(0, 47) == 0)
				burst_out = !burst_out;
			if (hold_request) begin
				gap = LONG_HOLD;
				hold_request = 1'b0;
			end else begin
				gap = burst_out ? 0 : $urandom_range(0, MAX_GAP);
			end
			if (gap != 0) begin
				result_if.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result_if.ready <= 1'b1;
			do @(posedge clk); while (!result_if.valid);
			last_address = result_if.next_address;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (fetch_if.valid && fetch_if.ready) ||
			(result_if.valid && result_if.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		ending_t     ending;
		int unsigned k;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		fetch_if.valid = 1'b0;
		fetch_if.instruction = '0;
		fetch_if.in_byte = '0;
		loop_depth = 0;
		skip_level = 0;
		words_sent = 0;
		last_address = '0;
		hold_request = 1'b0;
		burst_in = 1'b0;
		burst_out = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// above the program size, so it saturates
		write_length('1);

		send_word(CMD_PTR_DEC, 8'h00);
		send_word(CMD_CELL_DEC, 8'hFF);
		send_word(CMD_WRITE, 8'h00);
		send_word(CMD_CELL_INC, 8'h00);
		send_word(CMD_WRITE, 8'hFF);
		send_word(CMD_PTR_INC, 8'h00);
		send_word(CMD_READ, 8'hFF);
		send_word(CMD_CELL_INC, 8'h00);
		send_word(CMD_WRITE, 8'h00);
		// zero cell: skip the body, nested brackets included
		send_word(CMD_OPEN, 8'h00);
		send_word(CMD_WRITE, 8'hFF);
		send_word(CMD_OPEN, 8'hFF);
		send_word(8'hFF, 8'h00);
		send_word(CMD_CLOSE, 8'h00);
		send_word(CMD_CLOSE, 8'h00);
		send_word(CMD_READ, 8'h80);
		send_word(CMD_OPEN, 8'h00);
		send_word(CMD_CELL_DEC, 8'h00);
		send_word(CMD_CLOSE, 8'h00);
		send_word(CMD_READ, 8'h00);
		send_word(CMD_CLOSE, 8'h00);
		send_word(8'h00, 8'h55);
		send_word(CMD_WRITE, 8'hAA);

		while (words_sent < RANDOM_WORDS / 3)
			random_chunk();
		drain();
		write_length(PROG_SIZE);
		hold_request = 1'b1;
		while (words_sent < 2 * RANDOM_WORDS / 3)
			random_chunk();
		drain();
		write_length(ADDR_W'(last_address + $urandom_range(3000, 60000)));
		while (words_sent < RANDOM_WORDS)
			random_chunk();

		// leave skip mode and close every loop before the run is brought to a stop
		while (skip_level != 0) begin
			send_word(CMD_CLOSE, rand_byte());
			skip_level--;
		end
		while (loop_depth != 0)
			close_loop(1'b0);
		drain();

		ending = ending_t'($urandom_range(0, 5));
		case (ending)
		END_REACH: begin
			k = $urandom_range(1, 6);
			write_length(ADDR_W'(last_address + k));
			repeat (k) send_word(plain_command(), rand_byte());
		end
		END_BEYOND: begin
			write_length(ADDR_W'($urandom_range(0, last_address)));
			send_word(plain_command(), rand_byte());
		end
		END_UNMATCHED: begin
			send_word(CMD_CLOSE, rand_byte());
		end
		END_STACK_FULL: begin
			send_word(CMD_READ, 8'($urandom_range(1, 255)));
			repeat (FULL_RUN) send_word(CMD_OPEN, rand_byte());
		end
		END_SKIP_FULL: begin
			send_word(CMD_READ, 8'h00);
			repeat (FULL_RUN) send_word(CMD_OPEN, rand_byte());
		end
		default: begin
			k = $urandom_range(3, 8);
			write_length(ADDR_W'(last_address + k));
			send_word(CMD_READ, 8'h00);
			send_word(CMD_OPEN, rand_byte());
			repeat (k) send_word(plain_byte(), rand_byte());
		end
		endcase
		repeat (3) send_word(plain_byte(), rand_byte());
		drain();
		// the stop holds whatever length is written afterwards
		write_length('0);
		repeat (2) send_word(plain_command(), rand_byte());
		drain();
		write_length('1);
		repeat (2) send_word(plain_command(), rand_byte());
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (fail_count == 0 && pending_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: bf_tape_machine_step.f
+incdir+design
design/bftm_pkg.sv
design/bftm_if.sv
design/bftm_ram.sv
design/bf_tape_machine_step.sv
design/bftm_checker.sv
tb/tape_machine_checker.sv
tb/tb.sv
